// File: hw/rtl/dsg_pkg.sv
// Shared types and constants for the developer session gate.
// No dependencies; imported by every module of the block.
package dsg_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned ValW = 32;
  localparam int unsigned MaskW = 4;
  localparam int unsigned GateW = 5;
  localparam int unsigned InDataW = 104;
  localparam int unsigned InUserW = 2;
  localparam int unsigned OutDataW = 16;

  localparam logic [GateW-1:0] AllGates = 5'h1f;
  localparam logic [MaskW-1:0] BitAirN = 4'h1;
  localparam logic [MaskW-1:0] BitPrecharge = 4'h2;
  localparam logic [MaskW-1:0] BitAirP = 4'h4;
  localparam logic [MaskW-1:0] BitDcdc = 4'h8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEV_ALLOWED = 3'd0,
    REG_KEY_CONFIGURED = 3'd1,
    REG_BUILD_KEY = 3'd2,
    REG_ALLOWED_MASK = 3'd3,
    REG_KEEPALIVE_TIMEOUT = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_ENTER = 2'd1,
    CMD_SET = 2'd2,
    CMD_EXIT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_TEST = 2'd1,
    MODE_COMM = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_DENIED = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef struct packed {
    logic             dev_allowed;
    logic             key_configured;
    logic [ValW-1:0]  build_key;
    logic [MaskW-1:0] allowed_mask;
    logic [TimeW-1:0] keepalive_timeout;
  } cfg_t;

  typedef struct packed {
    mode_e            mode;
    logic [MaskW-1:0] test_mask;
    logic [TimeW-1:0] last_keepalive;
    logic             seen;
    logic             lost;
  } sess_t;

  typedef struct packed {
    cmd_e             cmd;
    logic [TimeW-1:0] now_time;
    logic [ValW-1:0]  value_a;
    logic [ValW-1:0]  value_b;
    logic             entry_permitted;
    logic             switches_low;
    logic [GateW-1:0] gate_bits;
    logic             hard_fault;
  } item_t;

  typedef struct packed {
    status_e          status;
    mode_e            mode_now;
    logic             mode_switched;
    logic             session_lost;
    logic [MaskW-1:0] drive;
  } res_t;

endpackage

// File: hw/rtl/dsg_cfg_regs.sv
// Configuration register file of the developer session gate.
// Depends on dsg_pkg for the register indexes and the cfg_t bundle.
module dsg_cfg_regs import dsg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [CfgIdxW-1:0]  idx_i,
  input  logic [CfgDataW-1:0] data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        REG_DEV_ALLOWED:       cfg_d.dev_allowed = data_i[0];
        REG_KEY_CONFIGURED:    cfg_d.key_configured = data_i[0];
        REG_BUILD_KEY:         cfg_d.build_key = data_i[ValW-1:0];
        REG_ALLOWED_MASK:      cfg_d.allowed_mask = data_i[MaskW-1:0];
        REG_KEEPALIVE_TIMEOUT: cfg_d.keepalive_timeout = data_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_allowed <= 1'b0;
      cfg_q.key_configured <= 1'b0;
      cfg_q.build_key <= '0;
      cfg_q.allowed_mask <= 4'hf;
      cfg_q.keepalive_timeout <= 32'd1000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/dsg_core.sv
// Combinational session logic: next session state and result for one item.
// Depends on dsg_pkg for the item, state, config and result types.
module dsg_core import dsg_pkg::*; (
  input  item_t item_i,
  input  sess_t sess_i,
  input  cfg_t  cfg_i,
  output sess_t sess_o,
  output res_t  res_o
);

  logic [TimeW-1:0] age_pre, age_post;
  logic             fresh_pre, fresh_post;
  logic             gates_ok;
  logic             mode_ok, key_ok, renewal;
  status_e          status;
  logic             changed;
  sess_t            nxt;

  assign gates_ok = (item_i.gate_bits == AllGates);
  assign age_pre = item_i.now_time - sess_i.last_keepalive;
  assign fresh_pre = sess_i.seen && (age_pre <= cfg_i.keepalive_timeout);
  assign mode_ok = (item_i.value_a == ValW'(MODE_TEST)) ||
                   (item_i.value_a == ValW'(MODE_COMM));
  assign key_ok = cfg_i.key_configured && (item_i.value_b == cfg_i.build_key);
  // only meaningful once mode_ok holds, so the low bits stand for the whole value
  assign renewal = (sess_i.mode == mode_e'(item_i.value_a[1:0])) && sess_i.seen;

  always_comb begin
    nxt = sess_i;
    status = ST_OK;
    changed = 1'b0;
    if (item_i.cmd == CMD_TICK) begin
      if (sess_i.mode == MODE_OFF) begin
        nxt.test_mask = '0;
      end else if (!fresh_pre) begin
        if (sess_i.mode == MODE_COMM) nxt.lost = 1'b1;
        nxt.mode = MODE_OFF;
        nxt.test_mask = '0;
        nxt.seen = 1'b0;
        changed = 1'b1;
      end else if (sess_i.mode == MODE_TEST && !gates_ok) begin
        nxt.test_mask = '0;
      end
    end else if (!cfg_i.dev_allowed) begin
      status = ST_DENIED;
    end else begin
      case (item_i.cmd)
        CMD_ENTER: begin
          if (!mode_ok || !key_ok) begin
            status = ST_INVALID;
          end else if (sess_i.mode != MODE_OFF && !renewal) begin
            status = ST_DENIED;
          end else if (!renewal && (!item_i.entry_permitted || !item_i.switches_low)) begin
            status = ST_DENIED;
          end else begin
            changed = (sess_i.mode != mode_e'(item_i.value_a[1:0]));
            nxt.mode = mode_e'(item_i.value_a[1:0]);
            if (!renewal) nxt.test_mask = '0;
            nxt.last_keepalive = item_i.now_time;
            nxt.seen = 1'b1;
            nxt.lost = 1'b0;
          end
        end
        CMD_SET: begin
          if (sess_i.mode != MODE_TEST || !fresh_pre) begin
            status = ST_DENIED;
          end else if ((item_i.value_a[ValW-1:MaskW] != '0) ||
                       ((item_i.value_a[MaskW-1:0] & ~cfg_i.allowed_mask) != '0)) begin
            status = ST_INVALID;
          end else begin
            nxt.test_mask = item_i.value_a[MaskW-1:0];
          end
        end
        default: begin  // exit
          changed = (sess_i.mode != MODE_OFF);
          if (sess_i.mode == MODE_COMM && !item_i.switches_low) nxt.lost = 1'b1;
          nxt.mode = MODE_OFF;
          nxt.test_mask = '0;
          nxt.seen = 1'b0;
        end
      endcase
    end
  end

  // drives look at the state after the item
  assign age_post = item_i.now_time - nxt.last_keepalive;
  assign fresh_post = nxt.seen && (age_post <= cfg_i.keepalive_timeout);

  always_comb begin
    res_o.status = status;
    res_o.mode_now = nxt.mode;
    res_o.mode_switched = changed;
    res_o.session_lost = nxt.lost;
    if (!item_i.hard_fault && nxt.mode == MODE_TEST && gates_ok && fresh_post) begin
      res_o.drive = nxt.test_mask & (BitAirN | BitPrecharge | BitAirP | BitDcdc);
    end else begin
      res_o.drive = '0;
    end
  end

  assign sess_o = nxt;

endmodule

// File: hw/rtl/developer_session_gate.sv
// Developer session gate top level: input register, session logic, result register.
// Depends on dsg_pkg, dsg_cfg_regs and dsg_core.
//
// Use:
//   Items enter on the s_axis group: the command in tuser, the time, values,
//   permission, switch, gate and fault flags in tdata. Each item gives one
//   result on the m_axis group: status, mode, mode-changed, lost flag and the
//   four switch drives.
//   Configuration registers are written on cfg_* by the user only while no
//   item is in flight, unenforced by the block; unused indexes are ignored.
// Timing:
//   An accepted item goes to the input register, is processed by dsg_core,
//   and its result is registered in the result register once that is free.
//   One item per cycle is sustained while m_axis_tready is high; session state
//   is updated with the result register, so back-to-back items see it.
// Reset and stall:
//   Reset empties both registers, closes the session and loads the register
//   defaults. While m_axis_tready is low the result holds and at most one
//   further item is taken into the input register; then s_axis_tready drops.
module developer_session_gate import dsg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: now_time[31:0], value_a[63:32], value_b[95:64], entry_permitted[96],
  //        switches_low[97], gate_bits[102:98], hard_fault[103]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser: cmd[1:0]
  input  logic [InUserW-1:0]  s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: status[1:0], mode_now[3:2], mode_switched[4], session_lost[5],
  //        drive_air_n[6], drive_precharge[7], drive_air_p[8], drive_dcdc[9], zero[15:10]
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t  cfg;
  item_t in_item_d, in_item_q;
  logic  in_valid_q;
  logic  out_valid_q;
  res_t  res_d, res_q;
  sess_t sess_d, sess_q;
  logic  out_free, fire, in_take;

  dsg_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  dsg_core u_core (
    .item_i (in_item_q),
    .sess_i (sess_q),
    .cfg_i  (cfg),
    .sess_o (sess_d),
    .res_o  (res_d)
  );

  assign out_free = !out_valid_q || m_axis_tready;
  assign fire = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_item_d.cmd = cmd_e'(s_axis_tuser[1:0]);
    in_item_d.now_time = s_axis_tdata[31:0];
    in_item_d.value_a = s_axis_tdata[63:32];
    in_item_d.value_b = s_axis_tdata[95:64];
    in_item_d.entry_permitted = s_axis_tdata[96];
    in_item_d.switches_low = s_axis_tdata[97];
    in_item_d.gate_bits = s_axis_tdata[102:98];
    in_item_d.hard_fault = s_axis_tdata[103];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      sess_q.mode <= MODE_OFF;
      sess_q.test_mask <= '0;
      sess_q.last_keepalive <= '0;
      sess_q.seen <= 1'b0;
      sess_q.lost <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        sess_q <= sess_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_item_q <= in_item_d;
    if (fire) res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {6'b0, res_q.drive, res_q.session_lost, res_q.mode_switched,
                         res_q.mode_now, res_q.status};

endmodule

// File: test/tb_top.sv
// Self-checking bench for developer_session_gate: directed session rules, then
// randomized command streams over several register settings, with bus stalls.
// Depends on dsg_pkg and the developer_session_gate RTL.
`timescale 1ns / 1ps

module tb_top;
  import dsg_pkg::*;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_COMB} sink_style_e;

  localparam int unsigned RandPhases = 10;
  localparam int unsigned PhaseItems = 150;
  localparam logic [31:0] DirKey = 32'hC0DE_1234;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // tdata: now_time, value_a, value_b, entry_permitted, switches_low, gate_bits,
  //        hard_fault (lowest bit up)
  logic [InDataW-1:0]  s_axis_tdata = '0;
  // tuser: cmd
  logic [InUserW-1:0]  s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  developer_session_gate dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the block's registers and session
  cfg_t  gate_cfg;
  sess_t sess;
  res_t  pending_responses[$];

  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int session_timeouts = 0;
  int status_tally[3] = '{0, 0, 0};
  int burst_left = 0;
  logic [31:0] stamp;

  function automatic logic keepalive_live(logic [31:0] now);
    logic [31:0] age;
    age = now - sess.last_keepalive;
    return sess.seen && (age <= gate_cfg.keepalive_timeout);
  endfunction

  function automatic void drop_session();
    sess.mode = MODE_OFF;
    sess.test_mask = '0;
    sess.seen = 1'b0;
  endfunction

  // Applies one command to the shadow session and returns the response it gives.
  function automatic res_t gate_response(item_t it);
    res_t r;
    logic gates_ok;
    logic renewal;
    mode_e want_mode;
    r = '0;
    r.status = ST_OK;
    gates_ok = (it.gate_bits == AllGates);
    want_mode = mode_e'(it.value_a[1:0]);
    if (it.cmd == CMD_TICK) begin
      if (sess.mode == MODE_OFF) begin
        sess.test_mask = '0;
      end else if (!keepalive_live(it.now_time)) begin
        if (sess.mode == MODE_COMM) sess.lost = 1'b1;
        drop_session();
        r.mode_switched = 1'b1;
        session_timeouts++;
      end else if (sess.mode == MODE_TEST && !gates_ok) begin
        sess.test_mask = '0;
      end
    end else if (!gate_cfg.dev_allowed) begin
      r.status = ST_DENIED;
    end else if (it.cmd == CMD_ENTER) begin
      if (it.value_a < 32'(MODE_TEST) || it.value_a > 32'(MODE_COMM)) begin
        r.status = ST_INVALID;
      end else if (!gate_cfg.key_configured || it.value_b != gate_cfg.build_key) begin
        r.status = ST_INVALID;
      end else begin
        renewal = (sess.mode == want_mode) && sess.seen;
        if (sess.mode != MODE_OFF && !renewal) begin
          r.status = ST_DENIED;
        end else if (!renewal && (!it.entry_permitted || !it.switches_low)) begin
          r.status = ST_DENIED;
        end else begin
          r.mode_switched = (sess.mode != want_mode);
          sess.mode = want_mode;
          if (!renewal) sess.test_mask = '0;
          sess.last_keepalive = it.now_time;
          sess.seen = 1'b1;
          sess.lost = 1'b0;
        end
      end
    end else if (it.cmd == CMD_SET) begin
      if (sess.mode != MODE_TEST || !keepalive_live(it.now_time)) begin
        r.status = ST_DENIED;
      end else if ((it.value_a & ~32'(gate_cfg.allowed_mask)) != '0) begin
        r.status = ST_INVALID;
      end else begin
        sess.test_mask = it.value_a[MaskW-1:0];
      end
    end else begin
      r.mode_switched = (sess.mode != MODE_OFF);
      if (sess.mode == MODE_COMM && !it.switches_low) sess.lost = 1'b1;
      drop_session();
    end
    // drives reflect the state after the command, at its own timestamp
    if (!it.hard_fault && sess.mode == MODE_TEST && gates_ok && keepalive_live(it.now_time))
      r.drive = sess.test_mask;
    r.mode_now = sess.mode;
    r.session_lost = sess.lost;
    status_tally[int'(r.status)]++;
    return r;
  endfunction

  function automatic item_t req(cmd_e c, logic [31:0] t, logic [31:0] va,
                                logic [31:0] vb = DirKey, logic perm = 1'b1,
                                logic swl = 1'b1, logic [GateW-1:0] gates = AllGates,
                                logic fault = 1'b0);
    item_t it;
    it.cmd = c;
    it.now_time = t;
    it.value_a = va;
    it.value_b = vb;
    it.entry_permitted = perm;
    it.switches_low = swl;
    it.gate_bits = gates;
    it.hard_fault = fault;
    return it;
  endfunction

  // Mostly well-formed requests (right key, legal modes, small time steps),
  // with a share of bad keys, bad modes, wild times and closed gates.
  function automatic item_t random_request();
    item_t it;
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      5, 6:    stamp = stamp + gate_cfg.keepalive_timeout + 32'($urandom_range(0, 2)) - 32'd1;
      7:       stamp = stamp + 32'($urandom_range(0, 200));
      8:       stamp = stamp + $urandom();
      9:       ;
      default: stamp = stamp + 32'($urandom_range(0, 3));
    endcase
    pick = $urandom_range(0, 19);
    it.cmd = (pick < 5) ? CMD_TICK : (pick < 11) ? CMD_ENTER : (pick < 17) ? CMD_SET : CMD_EXIT;
    it.now_time = stamp;
    it.value_a = $urandom();
    it.value_b = $urandom();
    pick = $urandom_range(0, 9);
    if (it.cmd == CMD_ENTER) begin
      if (pick < 8)
        it.value_a = 32'(($urandom_range(0, 1) == 0) ? MODE_TEST : MODE_COMM);
      else if (pick == 8)
        it.value_a = ($urandom_range(0, 1) == 0) ? 32'(MODE_OFF) : 32'd3;
      if ($urandom_range(0, 19) > 2) it.value_b = gate_cfg.build_key;
    end else if (it.cmd == CMD_SET) begin
      if (pick < 7) it.value_a = 32'($urandom_range(0, 15));
      else if (pick == 7) it.value_a = '0;
    end
    it.entry_permitted = ($urandom_range(0, 19) > 2);
    it.switches_low = ($urandom_range(0, 19) > 2);
    it.gate_bits = ($urandom_range(0, 4) != 0) ? AllGates : GateW'($urandom());
    it.hard_fault = ($urandom_range(0, 9) == 0);
    return it;
  endfunction

  task automatic send_item(input item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.cmd;
    s_axis_tdata <= {it.hard_fault, it.gate_bits, it.switches_low, it.entry_permitted,
                     it.value_b, it.value_a, it.now_time};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    pending_responses.push_back(gate_response(it));
    items_sent++;
  endtask

  // drain all outstanding results, then let the pipeline go idle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_responses.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_config(input cfg_t c);
    cfg_reg_e idx [5];
    logic [31:0] val [5];
    idx = '{REG_DEV_ALLOWED, REG_KEY_CONFIGURED, REG_BUILD_KEY, REG_ALLOWED_MASK,
            REG_KEEPALIVE_TIMEOUT};
    val = '{32'(c.dev_allowed), 32'(c.key_configured), c.build_key, 32'(c.allowed_mask),
            c.keepalive_timeout};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    gate_cfg = c;
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // result sink: checks every accepted response and stalls in shifting styles
  sink_style_e sink_style = SINK_OPEN;
  int sink_left = 0;

  always @(posedge clk_i) begin : sink
    res_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_responses.size() == 0) begin
        $error("response with nothing pending: tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_responses.pop_front();
        results_checked++;
        check_field("status", want.status, m_axis_tdata[1:0]);
        check_field("mode_now", want.mode_now, m_axis_tdata[3:2]);
        check_field("mode_switched", want.mode_switched, m_axis_tdata[4]);
        check_field("session_lost", want.session_lost, m_axis_tdata[5]);
        check_field("drive_air_n", want.drive[0], m_axis_tdata[6]);
        check_field("drive_precharge", want.drive[1], m_axis_tdata[7]);
        check_field("drive_air_p", want.drive[2], m_axis_tdata[8]);
        check_field("drive_dcdc", want.drive[3], m_axis_tdata[9]);
      end
    end
    if (sink_left == 0) begin
      sink_style = sink_style_e'($urandom_range(0, 3));
      sink_left = $urandom_range(16, 160);
    end
    sink_left--;
    case (sink_style)
      SINK_OPEN:   m_axis_tready <= 1'b1;
      SINK_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:     m_axis_tready <= (sink_left[2:0] != 3'd0);
    endcase
  end

  // With the reset profile, every request but a tick is refused.
  task automatic test_reset_profile();
    send_item(req(CMD_ENTER, 32'd5, 32'(MODE_TEST), 32'd0));
    send_item(req(CMD_SET, 32'd6, 32'hF, 32'd0));
    send_item(req(CMD_EXIT, 32'd7, 32'd0, 32'd0, 1'b1, 1'b0));
    wait_idle();
  endtask

  task automatic test_session_rules();
    cfg_t c;
    c.dev_allowed = 1'b1;
    c.key_configured = 1'b1;
    c.build_key = DirKey;
    c.allowed_mask = 4'hF;
    c.keepalive_timeout = 32'd1000;
    load_config(c);
    send_item(req(CMD_TICK, 32'd10, 32'd0));
    // enter refusals: bad mode, bad key, entry not permitted, switches up
    send_item(req(CMD_ENTER, 32'd20, 32'(MODE_OFF)));
    send_item(req(CMD_ENTER, 32'd21, 32'd3));
    send_item(req(CMD_ENTER, 32'd22, 32'hFFFF_FFFF));
    send_item(req(CMD_ENTER, 32'd23, 32'(MODE_TEST), DirKey ^ 32'h1));
    send_item(req(CMD_ENTER, 32'd24, 32'(MODE_TEST), DirKey, 1'b0));
    send_item(req(CMD_ENTER, 32'd25, 32'(MODE_TEST), DirKey, 1'b1, 1'b0));
    send_item(req(CMD_ENTER, 32'd100, 32'(MODE_TEST)));
    send_item(req(CMD_SET, 32'd150, 32'h10));
    send_item(req(CMD_SET, 32'd200, 32'hF));
    send_item(req(CMD_SET, 32'd210, 32'h5, DirKey, 1'b1, 1'b1, AllGates, 1'b1));
    send_item(req(CMD_TICK, 32'd220, 32'd0, DirKey, 1'b1, 1'b1, 5'h1E));
    send_item(req(CMD_SET, 32'd230, 32'hA));
    send_item(req(CMD_ENTER, 32'd240, 32'(MODE_COMM)));
    // renewal ignores permission and switches and keeps the mask
    send_item(req(CMD_ENTER, 32'd1000, 32'(MODE_TEST), DirKey, 1'b0, 1'b0));
    send_item(req(CMD_SET, 32'd2001, 32'h3));
    send_item(req(CMD_TICK, 32'd2001, 32'd0));
    // commissioning across the 32-bit wrap of the timestamp
    send_item(req(CMD_ENTER, 32'hFFFF_FF00, 32'(MODE_COMM)));
    send_item(req(CMD_SET, 32'hFFFF_FF10, 32'h1));
    send_item(req(CMD_TICK, 32'h0000_0200, 32'd0));
    send_item(req(CMD_EXIT, 32'h0000_0300, 32'd0, DirKey, 1'b1, 1'b0));
    send_item(req(CMD_ENTER, 32'h0000_0400, 32'(MODE_COMM)));
    send_item(req(CMD_TICK, 32'h0000_0400 + 32'd1001, 32'd0));
    send_item(req(CMD_EXIT, 32'h0000_0800, 32'd0));
    wait_idle();
  endtask

  task automatic test_random_phases();
    cfg_t c;
    for (int p = 0; p < RandPhases; p++) begin
      c.dev_allowed = ($urandom_range(0, 5) != 0);
      c.key_configured = ($urandom_range(0, 5) != 0);
      c.build_key = $urandom();
      c.allowed_mask = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 2))
        0:       c.keepalive_timeout = 32'($urandom_range(0, 50));
        1:       c.keepalive_timeout = 32'($urandom_range(500, 5000));
        default: c.keepalive_timeout = $urandom();
      endcase
      // first phases pin the register extremes
      case (p)
        0: begin
          c = '{1'b1, 1'b1, 32'h0, 4'hF, 32'd1000};
        end
        1: begin
          c = '{1'b1, 1'b1, 32'hFFFF_FFFF, 4'h0, 32'h0};
        end
        2: begin
          c.dev_allowed = 1'b1;
          c.key_configured = 1'b1;
          c.keepalive_timeout = 32'hFFFF_FFFF;
        end
        3: c.key_configured = 1'b0;
        4: c.dev_allowed = 1'b0;
        default: ;
      endcase
      load_config(c);
      stamp = $urandom();
      for (int n = 0; n < PhaseItems; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 48);
          if ($urandom_range(0, 2) != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk_i);
          end
        end
        burst_left--;
        send_item(random_request());
      end
      wait_idle();
    end
  endtask

  initial begin
    gate_cfg = '{1'b0, 1'b0, 32'h0, 4'hF, 32'd1000};
    sess = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_profile();
    test_session_rules();
    test_random_phases();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d commands (directed, then %0d register settings); %0d responses checked.",
             items_sent, RandPhases, results_checked);
    $display("Statuses ok/denied/invalid: %0d/%0d/%0d; %0d keepalive expiries.",
             status_tally[0], status_tally[1], status_tally[2], session_timeouts);
    if (mismatches == 0 && pending_responses.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d responses outstanding.", pending_responses.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
